[hw/rtl/thrust_curve_interpolator_defines.svh]
// ----------------------------------------------------------------------------
// Thrust curve interpolator assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THRUST_CURVE_INTERPOLATOR_DEFINES_SVH
`define THRUST_CURVE_INTERPOLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The condition must hold in every cycle out of reset.
`define TCI_ASSERT_ALWAYS(label, cond, msg) \
    `TCI_ASSERT_IMP(label, 1'b1, cond, msg)

`endif

[hw/rtl/tci_pkg.sv]
// ----------------------------------------------------------------------------
// Thrust curve interpolator package
// Field widths, request codes and the transaction types shared by all modules.
// ----------------------------------------------------------------------------
package tci_pkg;

    localparam int unsigned REQ_W   = 2;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned FORCE_W = 24;
    localparam int unsigned CFG_W   = 6;

    localparam logic [REQ_W-1:0] REQ_LOAD     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACTIVATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY    = 2'd2;

    localparam logic [CFG_W-1:0] POINT_COUNT_RESET = 6'd1;

    localparam int unsigned JOB_QDEPTH  = 2;
    localparam int unsigned JOB_QPTR_W  = $clog2(JOB_QDEPTH);
    localparam int unsigned JOB_QCNT_W  = $clog2(JOB_QDEPTH + 1);

    localparam int unsigned DIV_STEPS = FORCE_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [IDX_W-1:0]   entry_index;
        logic [TIME_W-1:0]  entry_time_us;
        logic [FORCE_W-1:0] entry_force;
        logic [TIME_W-1:0]  now_us;
    } t_in_item;

    typedef struct packed {
        logic [FORCE_W-1:0] force_res;
        logic               active;
    } t_out_item;

    typedef struct packed {
        logic               is_query;
        logic               active;
        logic [IDX_W-1:0]   entry_index;
        logic [TIME_W-1:0]  time_us;
        logic [FORCE_W-1:0] point_force;
    } t_job;

    typedef struct packed {
        logic [TIME_W-1:0]  point_time;
        logic [FORCE_W-1:0] point_force;
    } t_point;

endpackage

[hw/rtl/thrust_curve_interpolator.sv]
// ----------------------------------------------------------------------------
// Thrust curve interpolator
// Piecewise linear lookup of motor thrust against time since activation.
// ----------------------------------------------------------------------------
// The input side is a queue: a transaction is taken when push is high and full
// is low. Loads write a table point, an activate transaction records the start
// time once, and a query asks for the force at now_us. Only queries produce a
// result, which waits on o_item while empty is low and leaves when pop is high.
// The point count register is written through i_cfg_we and i_cfg_wdata.
// A two-entry job queue separates the front end from the back end. A load
// is written to the table as the back end takes it from the job queue. A
// query yields zero before activation, the force of the first point at or
// before it and of the last point at or after it; otherwise a table search
// (one point per cycle) is followed by the multiply, the 24-step serial
// divide and the output register. If the consumer stalls, one result waits
// in the output register, the back end holds the next one, and the front end
// keeps filling the job queue until full rises. Reset clears the activation,
// the queues and the point count to one; table contents are undefined until
// loaded.
// ----------------------------------------------------------------------------
module thrust_curve_interpolator #(
    parameter int unsigned MAX_POINTS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  tci_pkg::t_in_item         i_item,
    output logic                      empty,
    input  logic                      pop,
    output tci_pkg::t_out_item        o_item,
    input  logic                      i_cfg_we,
    input  logic [tci_pkg::CFG_W-1:0] i_cfg_wdata
);

    logic          job_valid;
    tci_pkg::t_job job;
    logic          job_pop;

    tci_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    tci_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_item)
    );

endmodule

[hw/rtl/tci_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module tci_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/tci_front.sv]
// ----------------------------------------------------------------------------
// Thrust curve interpolator front end
// Accepts input transactions, keeps the activation state, turns queries into
// elapsed times and queues loads and queries for the back end.
// ----------------------------------------------------------------------------
`include "thrust_curve_interpolator_defines.svh"

module tci_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tci_pkg::t_in_item i_item,
    output logic             o_full,
    output logic             o_job_valid,
    output tci_pkg::t_job    o_job,
    input  logic             i_job_pop
);

    logic                             r_armed;
    logic [tci_pkg::TIME_W-1:0]       r_start_us;
    tci_pkg::t_job                    r_slot [tci_pkg::JOB_QDEPTH];
    logic [tci_pkg::JOB_QPTR_W-1:0]   r_wr_ptr;
    logic [tci_pkg::JOB_QPTR_W-1:0]   r_rd_ptr;
    logic [tci_pkg::JOB_QCNT_W-1:0]   r_count;

    logic          accept;
    logic          q_push;
    logic          q_pop;
    tci_pkg::t_job new_job;

    assign o_full      = (r_count == tci_pkg::JOB_QCNT_W'(tci_pkg::JOB_QDEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_slot[r_rd_ptr];

    assign accept = i_push && !o_full;
    assign q_push = accept &&
                    (i_item.req_type inside {tci_pkg::REQ_LOAD, tci_pkg::REQ_QUERY});
    assign q_pop  = i_job_pop && o_job_valid;

    always_comb begin
        new_job.is_query    = (i_item.req_type == tci_pkg::REQ_QUERY);
        new_job.active      = r_armed;
        new_job.entry_index = i_item.entry_index;
        new_job.point_force = i_item.entry_force;
        if (new_job.is_query) begin
            new_job.time_us = i_item.now_us - r_start_us;
        end else begin
            new_job.time_us = i_item.entry_time_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_start_us <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (accept && (i_item.req_type == tci_pkg::REQ_ACTIVATE) && !r_armed) begin
                r_armed    <= 1'b1;
                r_start_us <= i_item.now_us;
            end
            if (q_push) begin
                r_slot[r_wr_ptr] <= new_job;
                r_wr_ptr         <= r_wr_ptr + tci_pkg::JOB_QPTR_W'(1);
            end
            if (q_pop) begin
                r_rd_ptr <= r_rd_ptr + tci_pkg::JOB_QPTR_W'(1);
            end
            if (q_push && !q_pop) begin
                r_count <= r_count + tci_pkg::JOB_QCNT_W'(1);
            end else if (q_pop && !q_push) begin
                r_count <= r_count - tci_pkg::JOB_QCNT_W'(1);
            end
        end
    end

    `TCI_ASSERT_ALWAYS(a_queue_bound, r_count <= tci_pkg::JOB_QCNT_W'(tci_pkg::JOB_QDEPTH), "job queue count overflow")
    `TCI_ASSERT_NXT(a_armed_sticky, r_armed, r_armed, "activation was lost")

endmodule

[hw/rtl/tci_back.sv]
// ----------------------------------------------------------------------------
// Thrust curve interpolator back end
// Writes table points, searches the table for a query and interpolates with a
// multiplier and a bit-serial divider, then holds the result for the consumer.
// ----------------------------------------------------------------------------
`include "thrust_curve_interpolator_defines.svh"

module tci_back #(
    parameter int unsigned MAX_POINTS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tci_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                         i_job_valid,
    input  tci_pkg::t_job                i_job,
    output logic                         o_job_pop,
    output logic                         o_empty,
    input  logic                         i_pop,
    output tci_pkg::t_out_item           o_item
);

    localparam int unsigned AW     = $clog2(MAX_POINTS);
    localparam int unsigned IW     = (AW > tci_pkg::IDX_W) ? AW : tci_pkg::IDX_W;
    localparam int unsigned FW     = tci_pkg::FORCE_W;
    localparam int unsigned TW     = tci_pkg::TIME_W;
    localparam int unsigned PROD_W = FW + TW;
    localparam int unsigned NUM_W  = PROD_W + 1;
    localparam int unsigned PW     = $bits(tci_pkg::t_point);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD0  = 4'd1;
    localparam logic [3:0] ST_RDL  = 4'd2;
    localparam logic [3:0] ST_SCAN = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_ADD  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_RES  = 4'd8;

    logic [3:0]                       r_state;
    logic [tci_pkg::CFG_W-1:0]        r_point_count;
    logic                             r_out_valid;
    tci_pkg::t_out_item               r_out;
    tci_pkg::t_out_item               r_res;
    logic [TW-1:0]                    r_e;
    tci_pkg::t_point                  r_prev;
    logic [AW-1:0]                    r_idx;
    logic [TW-1:0]                    r_dt;
    logic [TW-1:0]                    r_span;
    logic [FW-1:0]                    r_diff;
    logic                             r_dec;
    logic [PROD_W-1:0]                r_prod;
    logic [TW-1:0]                    r_rem;
    logic [FW-1:0]                    r_lo;
    logic [FW-1:0]                    r_quo;
    logic [tci_pkg::DIV_CNT_W-1:0]    r_cnt;

    logic [AW-1:0]     last;
    logic [IW-1:0]     widx;
    logic              load_ok;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    tci_pkg::t_point   ram_wpt;
    logic [AW-1:0]     ram_raddr;
    logic [PW-1:0]     ram_rdata;
    tci_pkg::t_point   rd_pt;
    logic              scan_more;
    logic              slot_free;
    logic [NUM_W-1:0]  num;
    logic [TW+1:0]     trial;

    tci_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wpt),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_pt = ram_rdata;

    always_comb begin
        if (r_point_count == '0) begin
            last = '0;
        end else if (32'(r_point_count) > 32'(MAX_POINTS)) begin
            last = AW'(MAX_POINTS - 1);
        end else begin
            last = AW'(r_point_count - tci_pkg::CFG_W'(1));
        end
    end

    assign widx      = IW'(i_job.entry_index);
    assign load_ok   = (32'(i_job.entry_index) < 32'(MAX_POINTS));
    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;
    assign ram_we    = o_job_pop && !i_job.is_query && load_ok;
    assign ram_waddr = widx[AW-1:0];
    assign ram_wpt   = '{point_time: i_job.time_us, point_force: i_job.point_force};
    assign scan_more = (r_idx < last) && (rd_pt.point_time < r_e);
    assign slot_free = !r_out_valid || i_pop;

    always_comb begin
        case (r_state)
            ST_RD0:  ram_raddr = last;
            ST_RDL:  ram_raddr = AW'(1);
            ST_SCAN: ram_raddr = r_idx + AW'(1);
            default: ram_raddr = '0;
        endcase
    end

    assign num   = {1'b0, r_prod} + (r_dec ? (NUM_W'(r_span) - NUM_W'(1)) : NUM_W'(0));
    assign trial = {1'b0, r_rem, r_lo[FW-1]} - {2'b00, r_span};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_point_count <= tci_pkg::POINT_COUNT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_point_count <= i_cfg_wdata;
            end
            if (r_out_valid && i_pop && (r_state != ST_RES)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_job_pop && i_job.is_query) begin
                        r_e <= i_job.time_us;
                        if (i_job.active) begin
                            r_state <= ST_RD0;
                        end else begin
                            r_res   <= '0;
                            r_state <= ST_RES;
                        end
                    end
                end
                ST_RD0: begin
                    r_prev <= rd_pt;
                    if (r_e <= rd_pt.point_time) begin
                        r_res   <= '{force_res: rd_pt.point_force, active: 1'b1};
                        r_state <= ST_RES;
                    end else begin
                        r_state <= ST_RDL;
                    end
                end
                ST_RDL: begin
                    if (r_e >= rd_pt.point_time) begin
                        r_res   <= '{force_res: rd_pt.point_force, active: 1'b1};
                        r_state <= ST_RES;
                    end else begin
                        r_idx   <= AW'(1);
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_more) begin
                        r_prev <= rd_pt;
                        r_idx  <= r_idx + AW'(1);
                    end else begin
                        r_dt    <= r_e - r_prev.point_time;
                        r_span  <= rd_pt.point_time - r_prev.point_time;
                        r_dec   <= (rd_pt.point_force < r_prev.point_force);
                        r_diff  <= (rd_pt.point_force < r_prev.point_force) ?
                                   (r_prev.point_force - rd_pt.point_force) :
                                   (rd_pt.point_force - r_prev.point_force);
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= PROD_W'(r_diff) * PROD_W'(r_dt);
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_rem   <= num[NUM_W-2:FW];
                    r_lo    <= num[FW-1:0];
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (!trial[TW+1]) begin
                        r_rem <= trial[TW-1:0];
                    end else begin
                        r_rem <= {r_rem[TW-2:0], r_lo[FW-1]};
                    end
                    r_quo <= {r_quo[FW-2:0], !trial[TW+1]};
                    r_lo  <= {r_lo[FW-2:0], 1'b0};
                    r_cnt <= r_cnt + tci_pkg::DIV_CNT_W'(1);
                    if (r_cnt == tci_pkg::DIV_CNT_W'(tci_pkg::DIV_STEPS - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_res.force_res <= r_dec ? (r_prev.point_force - r_quo) :
                                               (r_prev.point_force + r_quo);
                    r_res.active    <= 1'b1;
                    r_state         <= ST_RES;
                end
                ST_RES: begin
                    if (slot_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    `TCI_ASSERT_IMP(a_scan_bound, r_state == ST_SCAN, r_idx <= last, "search passed the last point")
    `TCI_ASSERT_IMP(a_div_rem, r_state == ST_DIV, r_rem < r_span, "divider remainder not below span")
    `TCI_ASSERT_IMP(a_quo_bound, r_state == ST_FIN, r_quo <= r_diff, "step exceeds force difference")

endmodule

[tb/thrust_curve_interpolator_checker.sv]
// ----------------------------------------------------------------------------
// Thrust curve interpolator checker
// Watches the input, result and register channels of the interpolator, keeps
// its own copy of the table, activation and point count, predicts the result
// of every accepted query and compares each popped result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thrust_curve_interpolator_checker #(
    parameter int unsigned MAX_POINTS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic                      i_full,
    input  tci_pkg::t_in_item         i_item,
    input  logic                      i_empty,
    input  logic                      i_pop,
    input  tci_pkg::t_out_item        i_result,
    input  logic                      i_cfg_we,
    input  logic [tci_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                        o_errors,
    output int                        o_pending
);

    logic [tci_pkg::TIME_W-1:0]  curve_time [MAX_POINTS];
    logic [tci_pkg::FORCE_W-1:0] curve_force [MAX_POINTS];
    logic                        motor_armed;
    logic [tci_pkg::TIME_W-1:0]  ignition_us;
    logic [tci_pkg::CFG_W-1:0]   point_count;
    tci_pkg::t_out_item          force_expect_q [$];
    tci_pkg::t_out_item          wanted;

    function automatic logic [tci_pkg::FORCE_W-1:0] interp_force(
        input logic [tci_pkg::TIME_W-1:0] elapsed);
        int unsigned used;
        int unsigned last;
        int unsigned k;
        logic [63:0] t0, t1, f0, f1, dt, span, part;
        if (point_count == 0) begin
            used = 1;
        end else if (point_count > MAX_POINTS) begin
            used = MAX_POINTS;
        end else begin
            used = point_count;
        end
        last = used - 1;
        if (elapsed <= curve_time[0]) return curve_force[0];
        if (elapsed >= curve_time[last]) return curve_force[last];
        k = 1;
        while (k < last && curve_time[k] < elapsed) k++;
        t0   = 64'(curve_time[k-1]);
        t1   = 64'(curve_time[k]);
        f0   = 64'(curve_force[k-1]);
        f1   = 64'(curve_force[k]);
        dt   = 64'(elapsed) - t0;
        span = t1 - t0;
        if (span == 0) return curve_force[k];
        if (f1 >= f0) begin
            part = ((f1 - f0) * dt) / span;
            return tci_pkg::FORCE_W'(f0 + part);
        end
        // A falling segment rounds the drop up so the force truncates toward zero.
        part = ((f0 - f1) * dt + span - 1) / span;
        return tci_pkg::FORCE_W'(f0 - part);
    endfunction

    task automatic predict_transaction(input tci_pkg::t_in_item it);
        tci_pkg::t_out_item res;
        case (it.req_type)
            tci_pkg::REQ_LOAD: begin
                if (it.entry_index < MAX_POINTS) begin
                    curve_time[it.entry_index]  = it.entry_time_us;
                    curve_force[it.entry_index] = it.entry_force;
                end
            end
            tci_pkg::REQ_ACTIVATE: begin
                if (!motor_armed) begin
                    motor_armed = 1'b1;
                    ignition_us = it.now_us;
                end
            end
            tci_pkg::REQ_QUERY: begin
                if (motor_armed) begin
                    res.force_res = interp_force(it.now_us - ignition_us);
                    res.active    = 1'b1;
                end else begin
                    res.force_res = '0;
                    res.active    = 1'b0;
                end
                force_expect_q = {force_expect_q, res};
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            motor_armed = 1'b0;
            ignition_us = '0;
            point_count = tci_pkg::POINT_COUNT_RESET;
            for (int k = 0; k < MAX_POINTS; k++) begin
                curve_time[k]  = '0;
                curve_force[k] = '0;
            end
            force_expect_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (force_expect_q.size() == 0) begin
                    $error("Result transaction with no query outstanding: force_res 0x%06h",
                           i_result.force_res);
                    o_errors++;
                end else begin
                    wanted = force_expect_q.pop_front();
                    if (i_result.force_res !== wanted.force_res) begin
                        $error("force_res mismatch: expected 0x%06h, actual 0x%06h",
                               wanted.force_res, i_result.force_res);
                        o_errors++;
                    end
                    if (i_result.active !== wanted.active) begin
                        $error("active mismatch: expected %0b, actual %0b",
                               wanted.active, i_result.active);
                        o_errors++;
                    end
                end
            end
            if (i_cfg_we) begin
                point_count = i_cfg_wdata;
            end
            if (i_push && !i_full) begin
                predict_transaction(i_item);
            end
        end
        o_pending = force_expect_q.size();
    end

endmodule

[tb/thrust_curve_interpolator_tb.sv]
// ----------------------------------------------------------------------------
// Thrust curve interpolator testbench
// Drives table loads, activations and queries in random bursts through the
// input queue, pops results with a varying stall pattern and runs through
// several point counts; the checker beside the block predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thrust_curve_interpolator_tb;
    import tci_pkg::*;

    localparam int unsigned NUM_POINTS    = 32;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned NUM_PHASES    = 10;
    localparam int unsigned PHASE_BODY    = 35;
    localparam int unsigned TIMEOUT_NS    = 2000000;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             push;
    logic             full;
    t_in_item         in_item;
    logic             empty;
    logic             pop = 1'b0;
    t_out_item        out_item;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               errors;
    int               pending;

    logic [TIME_W-1:0] curve_t [NUM_POINTS];
    logic [TIME_W-1:0] armed_at;
    int unsigned       used;
    int unsigned       burst_left;
    int unsigned       stall_left;
    int unsigned       stall_pct;
    int unsigned       stall_max;
    int unsigned       pattern_timer;

    always #1 clk = ~clk;

    thrust_curve_interpolator #(
        .MAX_POINTS (NUM_POINTS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_item      (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_item      (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    thrust_curve_interpolator_checker #(
        .MAX_POINTS (NUM_POINTS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_item      (in_item),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_result    (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        stall_left    = 0;
        stall_pct     = 0;
        stall_max     = 1;
        pattern_timer = 0;
    end

    always @(negedge clk) begin
        if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
        end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, stall_max);
        end
        pattern_timer++;
        if (pattern_timer >= 300) begin
            pattern_timer = 0;
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                2:       stall_pct = 40;
                default: stall_pct = 80;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_max = 2;
                1:       stall_max = 10;
                default: stall_max = 40;
            endcase
        end
    end

    function automatic t_in_item random_item();
        t_in_item it;
        it.req_type      = REQ_W'($urandom);
        it.entry_index   = IDX_W'($urandom);
        it.entry_time_us = $urandom;
        it.entry_force   = FORCE_W'($urandom);
        it.now_us        = $urandom;
        return it;
    endfunction

    function automatic logic [TIME_W-1:0] pick_elapsed();
        int unsigned k;
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        k = $urandom_range(0, used - 1);
        if ($urandom_range(0, 2) == 0) return curve_t[k] + $urandom_range(0, 2) - 1;
        lo = (curve_t[0] > 1000) ? curve_t[0] - 1000 : '0;
        hi = curve_t[used-1] + 1000;
        return $urandom_range(hi, lo);
    endfunction

    // Holds the transaction until it is taken, then closes the burst if it is spent.
    task automatic send(input t_in_item it);
        int unsigned gap;
        push    <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (full);
        if (it.req_type == REQ_LOAD) curve_t[it.entry_index] = it.entry_time_us;
        @(negedge clk);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            case ($urandom_range(0, 3))
                0:       burst_left = $urandom_range(1, 3);
                1:       burst_left = $urandom_range(4, 12);
                2:       burst_left = $urandom_range(20, 60);
                default: burst_left = $urandom_range(1, 8);
            endcase
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 70) : $urandom_range(0, 4);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic send_req(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] now);
        t_in_item it;
        it          = random_item();
        it.req_type = req;
        it.now_us   = now;
        send(it);
    endtask

    task automatic load_point(input int unsigned idx, input logic [TIME_W-1:0] t,
                              input logic [FORCE_W-1:0] f);
        t_in_item it;
        it               = random_item();
        it.req_type      = REQ_LOAD;
        it.entry_index   = IDX_W'(idx);
        it.entry_time_us = t;
        it.entry_force   = f;
        send(it);
    endtask

    task automatic load_curve(input int unsigned n);
        logic [TIME_W-1:0]  t;
        logic [FORCE_W-1:0] f;
        int unsigned        spread;
        case ($urandom_range(0, 2))
            0:       spread = 3;
            1:       spread = 2000;
            default: spread = 1 << 26;
        endcase
        t = $urandom_range(0, 1 << 20);
        for (int unsigned k = 0; k < n; k++) begin
            if (k > 0) t += $urandom_range(0, spread);
            if ($urandom_range(0, 3) == 0) begin
                f = $urandom_range(0, 1) ? {FORCE_W{1'b1}} : {FORCE_W{1'b0}};
            end else begin
                f = FORCE_W'($urandom);
            end
            load_point(k, t, f);
        end
    endtask

    // Waits for every outstanding result and for loads still in the pipeline.
    task automatic settle();
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_point_count(input int unsigned value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (value == 0) begin
            used = 1;
        end else if (value > NUM_POINTS) begin
            used = NUM_POINTS;
        end else begin
            used = value;
        end
    endtask

    task automatic random_transaction();
        t_in_item    it;
        int unsigned sel;
        it  = random_item();
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            it.req_type = REQ_QUERY;
            it.now_us   = armed_at + pick_elapsed();
        end else if (sel < 65) begin
            it.req_type = REQ_QUERY;
        end else if (sel < 78) begin
            it.req_type = REQ_LOAD;
        end else if (sel < 86) begin
            it.req_type = REQ_ACTIVATE;
        end else if (sel < 92) begin
            it.req_type = REQ_UNUSED;
        end else begin
            it.req_type = REQ_QUERY;
            it.now_us   = armed_at + curve_t[$urandom_range(0, used - 1)];
        end
        send(it);
    endtask

    initial begin
        #TIMEOUT_NS;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [TIME_W-1:0] probe [9];
        int unsigned       phase_cfg [NUM_PHASES];
        rst_n      = 1'b0;
        push       = 1'b0;
        in_item    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        used       = 1;
        burst_left = 1;
        armed_at   = '0;
        for (int k = 0; k < NUM_POINTS; k++) curve_t[k] = '0;
        probe     = '{32'd0, 32'd1000, 32'd1500, 32'd2000, 32'd2999, 32'd3500, 32'd4000,
                      32'hFFFF_FFFF, 32'd1001};
        phase_cfg = '{0, 2, 63, 7, 32, 1, 33, 3, 17, 5};
        phase_cfg[NUM_PHASES-1] = $urandom_range(0, 63);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_req(REQ_QUERY, 32'hFFFF_FFFF);
        send_req(REQ_UNUSED, $urandom);
        load_point(0, 32'd1000, 24'h000100);
        load_point(1, 32'd2000, 24'hFFFFFF);
        load_point(2, 32'd3000, 24'h000000);
        load_point(3, 32'd4000, 24'h123456);
        send_req(REQ_QUERY, 32'd0);
        send_req(REQ_ACTIVATE, 32'hFFFF_FF00);
        armed_at = 32'hFFFF_FF00;
        send_req(REQ_ACTIVATE, 32'd5);
        send_req(REQ_QUERY, armed_at);
        send_req(REQ_QUERY, armed_at + 32'd5000);
        write_point_count(4);
        foreach (probe[k]) send_req(REQ_QUERY, armed_at + probe[k]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_point_count(phase_cfg[p]);
            load_curve(used);
            for (int j = 0; j < PHASE_BODY; j++) random_transaction();
        end

        settle();
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
